### design/lbfac_pkg.sv
// Shared types and constants for the LCD bus field accumulating capture.
package lbfac_pkg;

	localparam int GroupCountDefault = 8192;
	localparam int GroupW = 13;
	localparam int QueueDepth = 4;
	localparam int InDataW = 8;
	localparam int OutDataW = 32;

	typedef enum logic [2:0] {
		PH_WAIT_LOW  = 3'b001,
		PH_WAIT_HIGH = 3'b010,
		PH_RUN       = 3'b100
	} phase_t;

	// Work handed from the front to the back; the store pointer travels beside it.
	typedef struct packed {
		logic              wr;
		logic              over;
		logic              first_field;
		logic [3:0]        bits;
		logic              buf_sel;
		logic [GroupW-1:0] group;
		logic              shown;
		logic              swapped;
		logic              active;
	} cmd_t;

	// Result item, write_valid in bit 0.
	typedef struct packed {
		logic              overrun;
		logic              capture_active;
		logic              frame_swapped;
		logic              shown_buffer;
		logic [1:0]        grey_three;
		logic [1:0]        grey_two;
		logic [1:0]        grey_one;
		logic [1:0]        grey_zero;
		logic [GroupW-1:0] write_group;
		logic              write_buffer;
		logic              write_valid;
	} res_t;

	// Saturating add of one data bit to a stored 2-bit grey level.
	function automatic logic [1:0] grey_add(input logic [1:0] old, input logic b);
		logic [2:0] sum;
		sum = {1'b0, old} + {2'b00, b};
		return sum[2] ? 2'd3 : sum[1:0];
	endfunction

endpackage

### design/lbfac_front.sv
// Bus sample classifier: start wait, edge detection, field and pointer tracking.
module lbfac_front #(
	parameter int GROUP_COUNT = lbfac_pkg::GroupCountDefault,
	parameter int PtrW = $clog2(GROUP_COUNT + 1),
	parameter int AddrW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lbfac_pkg::InDataW-1:0]        s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 q_full,
	output logic                                 push,
	output lbfac_pkg::cmd_t                      cmd,
	output logic [AddrW-1:0]                     cmd_ptr
);
	import lbfac_pkg::*;

	phase_t           phase_q, phase_nxt;
	logic             last_clk_q, last_clk_nxt;
	logic             last_pol_q, last_pol_nxt;
	logic [1:0]       field_q, field_nxt;
	logic [PtrW-1:0]  ptr_q, ptr_nxt;
	logic             back_q, back_nxt;
	logic             busy_q, busy_nxt;
	logic             active_q, active_nxt;
	logic             pix_clk, pol;
	logic [3:0]       bits;
	logic [PtrW+GroupW-1:0] ptr_ext;

	assign pix_clk  = s_tdata[0];
	assign pol      = s_tdata[1];
	assign bits     = s_tdata[5:2];
	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;
	assign ptr_ext  = {{GroupW{1'b0}}, ptr_q};

	always_comb begin
		phase_nxt    = phase_q;
		last_clk_nxt = last_clk_q;
		last_pol_nxt = last_pol_q;
		field_nxt    = field_q;
		ptr_nxt      = ptr_q;
		back_nxt     = back_q;
		busy_nxt     = busy_q;
		active_nxt   = active_q;
		cmd          = '0;
		cmd_ptr      = ptr_q[AddrW-1:0];
		cmd.bits     = bits;
		cmd.buf_sel  = back_q;
		cmd.group    = ptr_ext[GroupW-1:0];
		cmd.first_field = (field_q == 2'd0);
		if (s_tuser) begin
			busy_nxt = 1'b0;
		end else begin
			unique case (phase_q)
				PH_WAIT_LOW: begin
					if (!pol) phase_nxt = PH_WAIT_HIGH;
				end
				PH_WAIT_HIGH: begin
					if (pol) phase_nxt = PH_RUN;
				end
				PH_RUN: begin
					if (pix_clk && !last_clk_q) begin
						active_nxt = 1'b1;
						if (ptr_q >= PtrW'(GROUP_COUNT)) begin
							cmd.over = 1'b1;
						end else begin
							cmd.wr  = 1'b1;
							ptr_nxt = ptr_q + PtrW'(1);
						end
					end
					// polarity change closes the field and rewinds the pointer
					if (pol != last_pol_q) begin
						if (field_q >= 2'd2) begin
							if (!busy_q) begin
								back_nxt    = !back_q;
								busy_nxt    = 1'b1;
								cmd.swapped = 1'b1;
							end
							field_nxt = 2'd0;
						end else begin
							field_nxt = field_q + 2'd1;
						end
						ptr_nxt = '0;
					end
					last_clk_nxt = pix_clk;
					last_pol_nxt = pol;
				end
				default: phase_nxt = PH_WAIT_LOW;
			endcase
		end
		cmd.shown  = !back_nxt;
		cmd.active = active_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_LOW;
			last_clk_q <= 1'b0;
			last_pol_q <= 1'b1;
			field_q    <= 2'd0;
			ptr_q      <= '0;
			back_q     <= 1'b1;
			busy_q     <= 1'b1;
			active_q   <= 1'b0;
		end else if (push) begin
			phase_q    <= phase_nxt;
			last_clk_q <= last_clk_nxt;
			last_pol_q <= last_pol_nxt;
			field_q    <= field_nxt;
			ptr_q      <= ptr_nxt;
			back_q     <= back_nxt;
			busy_q     <= busy_nxt;
			active_q   <= active_nxt;
		end
	end

`ifndef SYNTHESIS
	a_no_write_before_run: assert property (@(posedge clk) disable iff (!arst_n)
		push && phase_q != PH_RUN |-> !cmd.wr && !cmd.over)
		else $error("write issued during start wait");
	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_q != 2'd3)
		else $error("field number out of range");
`endif

endmodule

### design/lbfac_queue.sv
// Short register queue between the front and the back.
module lbfac_queue #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [Width-1:0] pop_data
);
	import lbfac_pkg::*;

	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	logic [Width-1:0] slot_q [QueueDepth];
	logic [IdxW-1:0]  wr_idx_q, rd_idx_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(QueueDepth));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_idx_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_idx_q <= wr_idx_q + IdxW'(1);
			if (pop)  rd_idx_q <= rd_idx_q + IdxW'(1);
			if (push && !pop)      count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QueueDepth))
		else $error("queue count past depth");
`endif

endmodule

### design/lbfac_back.sv
// Pixel store read-modify-write and result register.
module lbfac_back #(
	parameter int AddrW = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  lbfac_pkg::cmd_t                 q_cmd,
	input  logic [AddrW-1:0]                q_ptr,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lbfac_pkg::OutDataW-1:0]  m_tdata
);
	import lbfac_pkg::*;

	localparam int MemAddrW = AddrW + 1;

	logic [7:0]          store_mem [2**MemAddrW];
	logic [7:0]          rdata_s1;
	cmd_t                cmd_s1;
	logic [MemAddrW-1:0] addr_s1;
	logic                valid_s1;
	logic                adv_s1;
	logic                fw_valid_q;
	logic [MemAddrW-1:0] fw_addr_q;
	logic [7:0]          fw_data_q;
	logic [7:0]          old_byte, new_byte;
	logic [MemAddrW-1:0] pop_addr;
	res_t                res_q, res_d;
	logic                out_valid_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign pop      = q_valid && (!valid_s1 || adv_s1);
	assign pop_addr = {q_cmd.buf_sel, q_ptr};

	// take the newest value when the previous item wrote the same entry
	assign old_byte = (fw_valid_q && fw_addr_q == addr_s1) ? fw_data_q : rdata_s1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			new_byte[2*i +: 2] = cmd_s1.first_field ? {1'b0, cmd_s1.bits[i]}
				: grey_add(old_byte[2*i +: 2], cmd_s1.bits[i]);
		end
		res_d                = '0;
		res_d.overrun        = cmd_s1.over;
		res_d.capture_active = cmd_s1.active;
		res_d.frame_swapped  = cmd_s1.swapped;
		res_d.shown_buffer   = cmd_s1.shown;
		if (cmd_s1.wr) begin
			res_d.write_valid  = 1'b1;
			res_d.write_buffer = cmd_s1.buf_sel;
			res_d.write_group  = cmd_s1.group;
			res_d.grey_zero    = new_byte[1:0];
			res_d.grey_one     = new_byte[3:2];
			res_d.grey_two     = new_byte[5:4];
			res_d.grey_three   = new_byte[7:6];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) rdata_s1 <= store_mem[pop_addr];
		if (adv_s1 && cmd_s1.wr) store_mem[addr_s1] <= new_byte;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= q_cmd;
			addr_s1 <= pop_addr;
		end
		if (adv_s1) res_q <= res_d;
		if (adv_s1 && cmd_s1.wr) begin
			fw_addr_q <= addr_s1;
			fw_data_q <= new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			fw_valid_q  <= 1'b0;
		end else begin
			if (pop)         valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;
			if (adv_s1)        out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (adv_s1 && cmd_s1.wr) fw_valid_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, res_q};

`ifndef SYNTHESIS
	a_write_or_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.write_valid && res_q.overrun))
		else $error("item both written and dropped");
	a_first_field_grey: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd_s1.wr && cmd_s1.first_field |->
			!new_byte[1] && !new_byte[3] && !new_byte[5] && !new_byte[7])
		else $error("first field stored more than one level");
`endif

endmodule

### design/lcd_bus_field_accumulating_capture.sv
// Top level of the LCD bus field accumulating capture.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: pixel_clock, frame_polarity, pixel_bits;
//         |     |                    | s_tuser: kind
// m_      | out | m_tvalid/m_tready  | m_tdata: write_valid .. overrun
//
// One item per cycle sustained while m_tready stays high; each accepted item passes
// through the front queue, the store read and the result register. The one read and one
// write of the pixel store per cycle set the rate; a forwarding register covers
// back-to-back touches of one entry. Reset clears all control state; the pixel store
// is not cleared. When m_tready is low the result register holds and the queue of
// four items absorbs input until s_tready drops.
module lcd_bus_field_accumulating_capture #(
	parameter int GROUP_COUNT = lbfac_pkg::GroupCountDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] pixel_clock, [1] frame_polarity, [5:2] pixel_bits, [7:6] zero
	input  logic [lbfac_pkg::InDataW-1:0]   s_tdata,
	// [0] kind
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] write_valid, [1] write_buffer, [14:2] write_group, [16:15] grey_zero,
	// [18:17] grey_one, [20:19] grey_two, [22:21] grey_three, [23] shown_buffer,
	// [24] frame_swapped, [25] capture_active, [26] overrun, [31:27] zero
	output logic [lbfac_pkg::OutDataW-1:0]  m_tdata
);
	import lbfac_pkg::*;

	localparam int PtrW = $clog2(GROUP_COUNT + 1);
	localparam int AddrW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int QW = $bits(cmd_t) + AddrW;

	logic             push, q_full, q_valid, pop;
	cmd_t             f_cmd, b_cmd;
	logic [AddrW-1:0] f_ptr, b_ptr;
	logic [QW-1:0]    q_out;

	lbfac_front #(
		.GROUP_COUNT(GROUP_COUNT),
		.PtrW(PtrW),
		.AddrW(AddrW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.cmd      (f_cmd),
		.cmd_ptr  (f_ptr)
	);

	lbfac_queue #(
		.Width(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_ptr, f_cmd}),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	assign b_cmd = q_out[$bits(cmd_t)-1:0];
	assign b_ptr = q_out[QW-1:$bits(cmd_t)];

	lbfac_back #(
		.AddrW(AddrW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (b_cmd),
		.q_ptr    (b_ptr),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### sim/tb_lcd_bus_field_accumulating_capture.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LCD bus field accumulating capture, directed then random traffic.
module tb_lcd_bus_field_accumulating_capture;
	import lbfac_pkg::*;

	localparam int GCOUNT = GroupCountDefault;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int QUIET_LO = 400;
	localparam int QUIET_HI = 800;
	localparam int RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic       kind;
		logic       clk;
		logic       pol;
		logic [3:0] bits;
	} bus_sample_t;

	// Mirrors the capture state and holds the results still to come.
	class grey_capture_tracker;
		phase_t      phase = PH_WAIT_LOW;
		logic        prev_clk = 1'b0;
		logic        prev_pol = 1'b1;
		int unsigned field = 0;
		int unsigned wptr = 0;
		logic        back = 1'b1;
		logic        busy = 1'b1;
		logic        active = 1'b0;
		logic [7:0]  store [0:2*GCOUNT-1];
		bit          written [0:2*GCOUNT-1];
		res_t        expected_captures [$];
		int          errors = 0;

		// Drop a clock edge that would accumulate onto an entry never written.
		function bus_sample_t make_legal(bus_sample_t s);
			if (!s.kind && phase == PH_RUN && s.clk && !prev_clk && field != 0
					&& wptr < GCOUNT && !written[back * GCOUNT + wptr])
				s.clk = 1'b0;
			return s;
		endfunction

		function void absorb_sample(bus_sample_t s);
			res_t        r;
			logic [7:0]  old_val;
			logic [7:0]  new_val;
			logic [2:0]  sum;
			int unsigned addr;
			r = '0;
			if (s.kind) begin
				busy = 1'b0;
			end else if (phase == PH_WAIT_LOW) begin
				if (!s.pol)
					phase = PH_WAIT_HIGH;
			end else if (phase == PH_WAIT_HIGH) begin
				if (s.pol)
					phase = PH_RUN;
			end else begin
				if (s.clk && !prev_clk) begin
					active = 1'b1;
					if (wptr >= GCOUNT) begin
						wptr = GCOUNT;
						r.overrun = 1'b1;
					end else begin
						addr = back * GCOUNT + wptr;
						old_val = written[addr] ? store[addr] : 8'h00;
						for (int i = 0; i < 4; i++) begin
							if (field == 0) begin
								new_val[2*i +: 2] = {1'b0, s.bits[i]};
							end else begin
								sum = {1'b0, old_val[2*i +: 2]} + {2'b00, s.bits[i]};
								new_val[2*i +: 2] = (sum > 3) ? 2'd3 : sum[1:0];
							end
						end
						store[addr] = new_val;
						written[addr] = 1'b1;
						r.write_valid = 1'b1;
						r.write_buffer = back;
						r.write_group = wptr[GroupW-1:0];
						r.grey_zero = new_val[1:0];
						r.grey_one = new_val[3:2];
						r.grey_two = new_val[5:4];
						r.grey_three = new_val[7:6];
						wptr++;
					end
				end
				if (s.pol != prev_pol) begin
					if (field >= 2) begin
						if (!busy) begin
							back = ~back;
							busy = 1'b1;
							r.frame_swapped = 1'b1;
						end
						field = 0;
					end else begin
						field++;
					end
					wptr = 0;
				end
				prev_clk = s.clk;
				prev_pol = s.pol;
			end
			r.shown_buffer = ~back;
			r.capture_active = active;
			expected_captures.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_capture(logic [OutDataW-1:0] d);
			res_t got;
			res_t want;
			got = res_t'(d[$bits(res_t)-1:0]);
			if (expected_captures.size() == 0) begin
				$error("unexpected result item %h", d);
				errors++;
				return;
			end
			want = expected_captures.pop_front();
			compare_field("write_valid", want.write_valid, got.write_valid);
			compare_field("write_buffer", want.write_buffer, got.write_buffer);
			compare_field("write_group", want.write_group, got.write_group);
			compare_field("grey_zero", want.grey_zero, got.grey_zero);
			compare_field("grey_one", want.grey_one, got.grey_one);
			compare_field("grey_two", want.grey_two, got.grey_two);
			compare_field("grey_three", want.grey_three, got.grey_three);
			compare_field("shown_buffer", want.shown_buffer, got.shown_buffer);
			compare_field("frame_swapped", want.frame_swapped, got.frame_swapped);
			compare_field("capture_active", want.capture_active, got.capture_active);
			compare_field("overrun", want.overrun, got.overrun);
			compare_field("padding", '0, d[OutDataW-1:$bits(res_t)]);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;

	int unsigned         cycles = 0;
	int unsigned         items_sent = 0;
	grey_capture_tracker tracker;

	lcd_bus_field_accumulating_capture #(
		.GROUP_COUNT(GCOUNT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic bit quiet_stretch();
		return cycles >= QUIET_LO && cycles < QUIET_HI;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_capture(m_tdata);
		m_tready <= (!quiet_stretch() && $urandom_range(99) < 16) ? 1'b0 : 1'b1;
	end

	task automatic push_sample(input bus_sample_t raw);
		bus_sample_t s;
		s = tracker.make_legal(raw);
		while (!quiet_stretch() && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= s.kind;
		s_tdata <= {2'b00, s.bits, s.pol, s.clk};
		do @(posedge clk); while (!s_tready);
		tracker.absorb_sample(s);
		items_sent++;
	endtask

	task automatic bus(input logic c, input logic p, input logic [3:0] b);
		bus_sample_t s;
		s.kind = 1'b0;
		s.clk = c;
		s.pol = p;
		s.bits = b;
		push_sample(s);
	endtask

	task automatic display_done();
		bus_sample_t s;
		s.kind = 1'b1;
		s.clk = 1'($urandom_range(1));
		s.pol = 1'($urandom_range(1));
		s.bits = 4'($urandom_range(15));
		push_sample(s);
	endtask

	task automatic clock_pulses(input int unsigned n);
		for (int unsigned k = 0; k < n; k++) begin
			bus(1'b1, tracker.prev_pol, 4'($urandom_range(15)));
			if ($urandom_range(99) < 3)
				display_done();
			bus(1'b0, tracker.prev_pol, 4'($urandom_range(15)));
		end
	endtask

	// Toggle polarity, sometimes on the same item as a clock edge.
	task automatic flip_polarity();
		bus(1'($urandom_range(1)), ~tracker.prev_pol, 4'($urandom_range(15)));
	endtask

	task automatic frame();
		for (int f = 0; f < 3; f++) begin
			clock_pulses($urandom_range(0, 12));
			if ($urandom_range(99) < 20)
				display_done();
			flip_polarity();
		end
	endtask

	task automatic noise(input int unsigned n);
		bus_sample_t s;
		for (int unsigned k = 0; k < n; k++) begin
			s.kind = ($urandom_range(99) < 10);
			s.clk = 1'($urandom_range(1));
			s.pol = 1'($urandom_range(1));
			s.bits = 4'($urandom_range(15));
			push_sample(s);
		end
	endtask

	initial begin
		int unsigned base;
		int unsigned pick;
		tracker = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start wait: edges are ignored, the sample that ends the wait is consumed.
		display_done();
		bus(1'b1, 1'b1, 4'hF);
		bus(1'b1, 1'b0, 4'hF);
		bus(1'b0, 1'b0, 4'h0);
		bus(1'b1, 1'b1, 4'hF);
		// Field 0
		bus(1'b1, 1'b1, 4'hF);
		bus(1'b0, 1'b1, 4'h0);
		bus(1'b1, 1'b1, 4'h0);
		bus(1'b0, 1'b1, 4'hF);
		// Field 1, then an edge together with a polarity change
		bus(1'b0, 1'b0, 4'h5);
		bus(1'b1, 1'b0, 4'hF);
		bus(1'b0, 1'b0, 4'h0);
		bus(1'b1, 1'b1, 4'hA);
		// Field 2
		bus(1'b0, 1'b1, 4'h0);
		bus(1'b1, 1'b1, 4'hF);
		bus(1'b0, 1'b1, 4'h0);
		display_done();
		bus(1'b0, 1'b0, 4'h0);
		// Into the other buffer; next wrap is blocked by a busy display
		bus(1'b1, 1'b0, 4'h3);
		bus(1'b0, 1'b0, 4'hC);
		bus(1'b0, 1'b1, 4'h0);
		bus(1'b0, 1'b0, 4'h0);
		bus(1'b0, 1'b1, 4'h0);

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 70)
				frame();
			else if (pick < 85)
				noise($urandom_range(1, 10));
			else
				display_done();
		end
		s_tvalid <= 1'b0;

		while (tracker.expected_captures.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
design/lbfac_pkg.sv
design/lbfac_front.sv
design/lbfac_queue.sv
design/lbfac_back.sv
design/lcd_bus_field_accumulating_capture.sv
sim/tb_lcd_bus_field_accumulating_capture.sv
